// ----- src/rdws_pkg.sv -----
// shared types and constants for the run duration window statistics block
package rdws_pkg;

    localparam int DUR_W  = 15;
    localparam int FUNC_W = 2;
    localparam int RUNS_W = 7;

    localparam logic [DUR_W-1:0] MAX_DUR = 15'h7FFF;

    // operation codes carried in the func field
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DUR_W-1:0]  duration;
    } t_in;

    typedef struct packed {
        logic [RUNS_W-1:0] runs_used;
        logic [DUR_W-1:0]  recent_min;
        logic [DUR_W-1:0]  recent_max;
        logic [DUR_W-1:0]  recent_avg;
        logic [DUR_W-1:0]  overall_min;
        logic [DUR_W-1:0]  overall_max;
        logic [DUR_W-1:0]  overall_avg;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DR_GO,
        S_DR_WAIT,
        S_DA_GO,
        S_DA_WAIT,
        S_DONE
    } t_state;

endpackage

// ----- src/rdws_ring.sv -----
// duration ring memory, one write port and one registered read port
module rdws_ring
    import rdws_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [DUR_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [DUR_W-1:0] o_rdata
);

    logic [DUR_W-1:0] r_mem [DEPTH];
    logic [DUR_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data registered and valid in the cycle after an enabled read address
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/rdws_div.sv -----
// restoring divider, one quotient bit per cycle
module rdws_div #(
    parameter int W  = 22,
    parameter int DW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [W-1:0]  o_quotient
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [W-1:0]  r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;

    logic [DW:0]   w_shift;
    logic [DW:0]   w_diff;

    // trial subtraction of the divisor from the shifted remainder
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CW'(1));
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!w_diff[DW]) begin
                r_rem <= w_diff[DW-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DW-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- src/run_duration_window_stats_core.sv -----
// Run duration window statistics core: ring of durations with min/max/average query.
// Add and clear items do not raise busy; busy stays low and the next item is taken at once.
// A query with n > 0 entries uses a divider of W = 15 + clog2(depth + 1) bits:
// the ring walk reads one memory entry per cycle, then one shared divider runs twice.
// A query on an empty ring skips the divider; the strobe is high for one cycle, never stalled.
// Synchronous active-low reset empties the ring (pointer and count to zero); no clearing pass.
module run_duration_window_stats_core
    import rdws_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int RECENT_WINDOW = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = DUR_W + CNT_W;
    localparam int RSUM_W = DUR_W + $clog2(RECENT_WINDOW + 1);

    t_state r_state, n_state;

    logic [PTR_W-1:0] r_wp;
    logic [CNT_W-1:0] r_fill;
    logic             r_strobe;
    t_out             r_out;

    logic [PTR_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_left;
    logic              r_rd_vld;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_used;
    logic [CNT_W-1:0]  r_recent_n;
    logic [DUR_W-1:0]  r_rmin, r_rmax, r_amin, r_amax, r_ravg;
    logic [RSUM_W-1:0] r_rsum;
    logic [SUM_W-1:0]  r_asum;

    logic             w_accept;
    logic             w_rd_en;
    logic             w_div_start;
    logic [SUM_W-1:0] w_div_dividend;
    logic [CNT_W-1:0] w_div_divisor;
    logic             w_div_done;
    logic [SUM_W-1:0] w_div_quo;
    logic [PTR_W-1:0] w_prev_pos;
    logic [CNT_W-1:0] w_recent_n;
    logic [DUR_W-1:0] w_rdata;
    logic [31:0]      w_used_ext;

    assign w_accept = start && !busy;

    // ring walks backward from the write pointer
    assign w_prev_pos = (r_pos == '0) ? PTR_W'(HISTORY_DEPTH - 1) : r_pos - 1'b1;

    // recent window size for the current fill
    assign w_recent_n = (int'(r_fill) < RECENT_WINDOW) ? r_fill : CNT_W'(RECENT_WINDOW);

    rdws_ring #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (PTR_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_item.func == FUNC_ADD)),
        .i_waddr (r_wp),
        .i_wdata (i_item.duration),
        .i_re    (w_rd_en),
        .i_raddr (w_prev_pos),
        .o_rdata (w_rdata)
    );

    rdws_div #(
        .W  (SUM_W),
        .DW (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_item.func == FUNC_QUERY)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if ((r_left == '0) && !r_rd_vld) begin
                    n_state = (r_used == '0) ? S_DONE : S_DR_GO;
                end
            end
            S_DR_GO:   n_state = S_DR_WAIT;
            S_DR_WAIT: begin
                if (w_div_done) begin
                    n_state = S_DA_GO;
                end
            end
            S_DA_GO:   n_state = S_DA_WAIT;
            S_DA_WAIT: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy           = 1'b1;
        w_rd_en        = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = r_asum;
        w_div_divisor  = r_used;
        case (r_state)
            S_IDLE: busy = 1'b0;
            S_WALK: w_rd_en = (r_left != '0);
            S_DR_GO: begin
                w_div_start    = 1'b1;
                w_div_dividend = SUM_W'(r_rsum);
                w_div_divisor  = r_recent_n;
            end
            S_DA_GO: w_div_start = 1'b1;
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_fill   <= '0;
            r_strobe <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_DONE);
            r_rd_vld <= w_rd_en;
            if (w_accept) begin
                case (i_item.func)
                    FUNC_ADD: begin
                        r_wp <= (r_wp == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        if (r_fill < CNT_W'(HISTORY_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                    FUNC_CLEAR: begin
                        r_wp   <= '0;
                        r_fill <= '0;
                    end
                    default: begin
                        r_wp <= r_wp;
                    end
                endcase
            end
        end
    end

    // walk and accumulate
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_item.func == FUNC_QUERY)) begin
            r_pos      <= r_wp;
            r_left     <= r_fill;
            r_used     <= r_fill;
            r_recent_n <= w_recent_n;
            r_idx      <= '0;
            r_rmin     <= MAX_DUR;
            r_rmax     <= '0;
            r_rsum     <= '0;
            r_amin     <= MAX_DUR;
            r_amax     <= '0;
            r_asum     <= '0;
        end else begin
            if (w_rd_en) begin
                r_pos  <= w_prev_pos;
                r_left <= r_left - 1'b1;
            end
            if (r_rd_vld) begin
                r_idx  <= r_idx + 1'b1;
                r_asum <= r_asum + SUM_W'(w_rdata);
                if (w_rdata < r_amin) r_amin <= w_rdata;
                if (w_rdata > r_amax) r_amax <= w_rdata;
                if (r_idx < r_recent_n) begin
                    r_rsum <= r_rsum + RSUM_W'(w_rdata);
                    if (w_rdata < r_rmin) r_rmin <= w_rdata;
                    if (w_rdata > r_rmax) r_rmax <= w_rdata;
                end
            end
            if ((r_state == S_DR_WAIT) && w_div_done) begin
                r_ravg <= w_div_quo[DUR_W-1:0];
            end
        end
    end

    assign w_used_ext = 32'(r_used);

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_out.runs_used <= w_used_ext[RUNS_W-1:0];
            if (r_used == '0) begin
                r_out.recent_min  <= '0;
                r_out.recent_max  <= '0;
                r_out.recent_avg  <= '0;
                r_out.overall_min <= '0;
                r_out.overall_max <= '0;
                r_out.overall_avg <= '0;
            end else begin
                r_out.recent_min  <= r_rmin;
                r_out.recent_max  <= r_rmax;
                r_out.recent_avg  <= r_ravg;
                r_out.overall_min <= r_amin;
                r_out.overall_max <= r_amax;
                r_out.overall_avg <= w_div_quo[DUR_W-1:0];
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef SYNTH
    // a query item always makes the block busy on the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.func == FUNC_QUERY)) |=> busy)
        else $error("query accepted but block not busy");

    // result strobes never come on consecutive cycles
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    // recent statistics are ordered
    a_recent_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_result.recent_min <= o_result.recent_avg)
                      && (o_result.recent_avg <= o_result.recent_max)))
        else $error("recent min/avg/max out of order");

    // overall statistics are ordered
    a_overall_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_result.overall_min <= o_result.overall_avg)
                      && (o_result.overall_avg <= o_result.overall_max)))
        else $error("overall min/avg/max out of order");
`endif

endmodule
